// ----- hw/rtl/decimal96_compare_macros.svh -----
// ----------------------------------------------------------------------------
// decimal96_compare macros
// assertion shorthands used by the checker file dc96_checker
// ----------------------------------------------------------------------------
`ifndef DECIMAL96_COMPARE_MACROS_SVH
`define DECIMAL96_COMPARE_MACROS_SVH

// checked on every clock edge once reset is released
`define DC96_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define DC96_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/dc96_pkg.sv -----
// ----------------------------------------------------------------------------
// dc96_pkg
// shared types, result codes and the power-of-ten table for decimal96_compare
// ----------------------------------------------------------------------------
package dc96_pkg;

	localparam int MANT_W  = 96;
	localparam int SCALE_W = 5;
	localparam int LIMB_W  = 32;
	localparam int LIMBS   = 3;
	localparam int MAX_POW = 28;

	typedef logic [MANT_W-1:0] mant_t;
	typedef logic [SCALE_W-1:0] scale_t;
	typedef logic signed [1:0] order_t;

	localparam order_t ORD_LT = 2'sb11;
	localparam order_t ORD_EQ = 2'sb00;
	localparam order_t ORD_GT = 2'sb01;

	typedef struct packed {
		logic   decided;
		order_t fixed;
		logic   invert;
		logic   big;
	} ctl_t;

	// entries past MAX_POW hold zero and are never relied on, big covers them
	localparam mant_t POW10 [0:31] = '{
		96'd1,
		96'd10,
		96'd100,
		96'd1000,
		96'd10000,
		96'd100000,
		96'd1000000,
		96'd10000000,
		96'd100000000,
		96'd1000000000,
		96'd10000000000,
		96'd100000000000,
		96'd1000000000000,
		96'd10000000000000,
		96'd100000000000000,
		96'd1000000000000000,
		96'd10000000000000000,
		96'd100000000000000000,
		96'd1000000000000000000,
		96'd10000000000000000000,
		96'd100000000000000000000,
		96'd1000000000000000000000,
		96'd10000000000000000000000,
		96'd100000000000000000000000,
		96'd1000000000000000000000000,
		96'd10000000000000000000000000,
		96'd100000000000000000000000000,
		96'd1000000000000000000000000000,
		96'd10000000000000000000000000000,
		96'd0,
		96'd0,
		96'd0
	};

endpackage

// ----- hw/rtl/dc96_prep.sv -----
// ----------------------------------------------------------------------------
// dc96_prep
// stage one: zero and sign decisions, operand swap and power-of-ten lookup
// ----------------------------------------------------------------------------
module dc96_prep (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             req_valid,
	input  logic [63:0]      a_mant_low,
	input  logic [31:0]      a_mant_high,
	input  dc96_pkg::scale_t a_scale,
	input  logic             a_negative,
	input  logic [63:0]      b_mant_low,
	input  logic [31:0]      b_mant_high,
	input  dc96_pkg::scale_t b_scale,
	input  logic             b_negative,
	output logic             v_s1,
	output dc96_pkg::ctl_t   ctl_s1,
	output dc96_pkg::mant_t  x_s1,
	output dc96_pkg::mant_t  y_s1,
	output dc96_pkg::mant_t  pow_s1
);
	import dc96_pkg::*;

	mant_t  a_m;
	mant_t  b_m;
	logic   za;
	logic   zb;
	logic   swap;
	scale_t diff;
	ctl_t   ctl;

	assign a_m  = {a_mant_high, a_mant_low};
	assign b_m  = {b_mant_high, b_mant_low};
	assign za   = (a_m == '0);
	assign zb   = (b_m == '0);
	assign swap = (b_scale < a_scale);
	assign diff = swap ? (a_scale - b_scale) : (b_scale - a_scale);

	always_comb begin
		ctl.decided = 1'b1;
		ctl.fixed   = ORD_EQ;
		ctl.invert  = swap ^ a_negative;
		ctl.big     = (diff > scale_t'(MAX_POW));
		if (za && zb) begin
			ctl.fixed = ORD_EQ;
		end else if (zb) begin
			ctl.fixed = a_negative ? ORD_LT : ORD_GT;
		end else if (za) begin
			ctl.fixed = b_negative ? ORD_GT : ORD_LT;
		end else if (a_negative != b_negative) begin
			ctl.fixed = a_negative ? ORD_LT : ORD_GT;
		end else begin
			ctl.decided = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl;
			x_s1   <= swap ? b_m : a_m;
			y_s1   <= swap ? a_m : b_m;
			pow_s1 <= POW10[diff];
		end
	end

endmodule

// ----- hw/rtl/dc96_mul.sv -----
// ----------------------------------------------------------------------------
// dc96_mul
// stages two to four: 96 by 96 bit product from 32-bit partial products
// ----------------------------------------------------------------------------
module dc96_mul (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            v_s1,
	input  dc96_pkg::ctl_t  ctl_s1,
	input  dc96_pkg::mant_t x_s1,
	input  dc96_pkg::mant_t y_s1,
	input  dc96_pkg::mant_t pow_s1,
	output logic            v_s4,
	output dc96_pkg::ctl_t  ctl_s4,
	output dc96_pkg::mant_t y_s4,
	output dc96_pkg::mant_t prod_s4,
	output logic            ovf_s4
);
	import dc96_pkg::*;

	localparam int PP_W  = 2 * LIMB_W;
	localparam int ROW_W = MANT_W + LIMB_W;
	localparam int FULL_W = 2 * MANT_W;

	logic [PP_W-1:0]  pp_s2 [LIMBS][LIMBS];
	logic [PP_W-1:0]  pp    [LIMBS][LIMBS];
	logic [ROW_W-1:0] row_s3 [LIMBS];
	logic [ROW_W-1:0] row   [LIMBS];
	logic [FULL_W-1:0] full;
	logic             v_s2;
	logic             v_s3;
	ctl_t             ctl_s2;
	ctl_t             ctl_s3;
	mant_t            y_s2;
	mant_t            y_s3;

	always_comb begin
		for (int i = 0; i < LIMBS; i++) begin
			for (int j = 0; j < LIMBS; j++) begin
				pp[i][j] = PP_W'(x_s1[i*LIMB_W +: LIMB_W]) * PP_W'(pow_s1[j*LIMB_W +: LIMB_W]);
			end
		end
	end

	// row j holds x times limb j of the power
	always_comb begin
		for (int j = 0; j < LIMBS; j++) begin
			row[j] = {{(ROW_W-PP_W){1'b0}}, pp_s2[0][j]}
				+ {{(ROW_W-PP_W-LIMB_W){1'b0}}, pp_s2[1][j], {LIMB_W{1'b0}}}
				+ {pp_s2[2][j], {(2*LIMB_W){1'b0}}};
		end
	end

	assign full = {{(FULL_W-ROW_W){1'b0}}, row_s3[0]}
		+ {{(FULL_W-ROW_W-LIMB_W){1'b0}}, row_s3[1], {LIMB_W{1'b0}}}
		+ {row_s3[2], {(2*LIMB_W){1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s2   <= pp;
			ctl_s2  <= ctl_s1;
			y_s2    <= y_s1;
			row_s3  <= row;
			ctl_s3  <= ctl_s2;
			y_s3    <= y_s2;
			prod_s4 <= full[MANT_W-1:0];
			ovf_s4  <= ctl_s3.big || (full[FULL_W-1:MANT_W] != '0);
			ctl_s4  <= ctl_s3;
			y_s4    <= y_s3;
		end
	end

endmodule

// ----- hw/rtl/dc96_cmp.sv -----
// ----------------------------------------------------------------------------
// dc96_cmp
// stage five: magnitude compare, sign fix-up and the output register
// ----------------------------------------------------------------------------
module dc96_cmp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             v_s4,
	input  dc96_pkg::ctl_t   ctl_s4,
	input  dc96_pkg::mant_t  y_s4,
	input  dc96_pkg::mant_t  prod_s4,
	input  logic             ovf_s4,
	output logic             rsp_valid,
	output dc96_pkg::order_t order
);
	import dc96_pkg::*;

	order_t mag;
	order_t res;

	always_comb begin
		if (ovf_s4 || (prod_s4 > y_s4)) begin
			mag = ORD_GT;
		end else if (prod_s4 < y_s4) begin
			mag = ORD_LT;
		end else begin
			mag = ORD_EQ;
		end
		if (ctl_s4.decided) begin
			res = ctl_s4.fixed;
		end else if (ctl_s4.invert) begin
			res = -mag;
		end else begin
			res = mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (en) begin
			rsp_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			order <= res;
		end
	end

endmodule

// ----- hw/rtl/decimal96_compare.sv -----
// ----------------------------------------------------------------------------
// decimal96_compare
// three-way compare of two signed 96-bit decimal numbers, five-stage pipeline
// ----------------------------------------------------------------------------
// channel  | handshake            | payload
// request  | req_valid, req_stall | a_*, b_* mantissa, scale, sign
// response | rsp_valid, rsp_stall | order
//
// one transaction per cycle while a stalled response does not hold the pipeline
// the 96 by 96 bit scaling product sets the depth: partial products,
// row sums and the final sum each take a stage
// reset clears the stage valid bits only
// a stalled response freezes every stage, req_stall follows it directly
// ----------------------------------------------------------------------------
module decimal96_compare (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  logic [63:0]      a_mant_low,
	input  logic [31:0]      a_mant_high,
	input  dc96_pkg::scale_t a_scale,
	input  logic             a_negative,
	input  logic [63:0]      b_mant_low,
	input  logic [31:0]      b_mant_high,
	input  dc96_pkg::scale_t b_scale,
	input  logic             b_negative,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output dc96_pkg::order_t order
);
	import dc96_pkg::*;

	logic  en;
	logic  v_s1;
	logic  v_s4;
	ctl_t  ctl_s1;
	ctl_t  ctl_s4;
	mant_t x_s1;
	mant_t y_s1;
	mant_t pow_s1;
	mant_t y_s4;
	mant_t prod_s4;
	logic  ovf_s4;

	assign en        = !(rsp_valid && rsp_stall);
	assign req_stall = !en;

	dc96_prep u_prep (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.req_valid   (req_valid),
		.a_mant_low  (a_mant_low),
		.a_mant_high (a_mant_high),
		.a_scale     (a_scale),
		.a_negative  (a_negative),
		.b_mant_low  (b_mant_low),
		.b_mant_high (b_mant_high),
		.b_scale     (b_scale),
		.b_negative  (b_negative),
		.v_s1        (v_s1),
		.ctl_s1      (ctl_s1),
		.x_s1        (x_s1),
		.y_s1        (y_s1),
		.pow_s1      (pow_s1)
	);

	dc96_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_s1    (v_s1),
		.ctl_s1  (ctl_s1),
		.x_s1    (x_s1),
		.y_s1    (y_s1),
		.pow_s1  (pow_s1),
		.v_s4    (v_s4),
		.ctl_s4  (ctl_s4),
		.y_s4    (y_s4),
		.prod_s4 (prod_s4),
		.ovf_s4  (ovf_s4)
	);

	dc96_cmp u_cmp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.v_s4      (v_s4),
		.ctl_s4    (ctl_s4),
		.y_s4      (y_s4),
		.prod_s4   (prod_s4),
		.ovf_s4    (ovf_s4),
		.rsp_valid (rsp_valid),
		.order     (order)
	);

endmodule

// ----- hw/rtl/dc96_checker.sv -----
// ----------------------------------------------------------------------------
// dc96_checker
// port-level checks on decimal96_compare, bound to the top level
// ----------------------------------------------------------------------------
`include "decimal96_compare_macros.svh"

module dc96_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             req_stall,
	input logic             rsp_valid,
	input logic             rsp_stall,
	input dc96_pkg::order_t order
);
	import dc96_pkg::*;

	`DC96_ASSERT_ALWAYS(a_stall_follows, req_stall == (rsp_valid && rsp_stall), "req_stall mismatch")
	`DC96_ASSERT(a_order_code, rsp_valid |-> (order >= ORD_LT), "bad order code")
	`DC96_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(order), "response moved")
	`DC96_ASSERT(a_no_rsp_from_idle, $rose(rsp_valid) |-> $past(!req_stall), "rose in a stall")

endmodule

bind decimal96_compare dc96_checker u_dc96_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.order     (order)
);
